@@ design/jddf_pkg.sv @@
// ----------------------------------------------------------------------------
// jddf_pkg
// Shared constants and controller/datapath interface types for the justified
// decimal digit formatter.
// ----------------------------------------------------------------------------
package jddf_pkg;

  localparam int MaxDigits   = 10;  // display positions available
  localparam int NumDec      = 10;  // decimal digits of a 31-bit magnitude
  localparam int ValueW      = 32;
  localparam int DigitW      = 4;
  localparam int PosW        = 4;
  localparam int BcdW        = NumDec * DigitW;
  localparam int BitsPerStep = 4;
  localparam int ConvSteps   = ValueW / BitsPerStep;
  localparam int StepCntW    = $clog2(ConvSteps);
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 4;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegDigitCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLeftAlign  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegZeroFill   = 2'd2;

  localparam logic [PosW-1:0] DigitCountReset = 4'd10;

  typedef struct packed {
    logic load;   // capture the accepted request and clear the converter
    logic step;   // run one conversion step
    logic emit;   // load the output register with the current position
  } jddf_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
    logic last_pos;  // current position is the final one in use
  } jddf_status_t;

endpackage

@@ design/jddf_ctrl.sv @@
// ----------------------------------------------------------------------------
// jddf_ctrl
// Sequencer: accepts a request, runs the conversion steps, then walks the
// display positions as the output register frees up.
// ----------------------------------------------------------------------------
module jddf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  jddf_pkg::jddf_status_t status_i,
  output jddf_pkg::jddf_cmd_t    cmd_o
);
  import jddf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(ConvSteps - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_pos) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ design/jddf_datapath.sv @@
// ----------------------------------------------------------------------------
// jddf_datapath
// Configuration registers, shift-and-add-3 binary to BCD converter and the
// per-position digit selection with its output register.
// ----------------------------------------------------------------------------
module jddf_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_write_i,
  input  logic [jddf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [jddf_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic signed [jddf_pkg::ValueW-1:0] value_i,
  input  jddf_pkg::jddf_cmd_t              cmd_i,
  output jddf_pkg::jddf_status_t           status_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [jddf_pkg::PosW-1:0]        position_o,
  output logic [jddf_pkg::DigitW-1:0]      digit_o,
  output logic                             blank_o,
  output logic                             last_o
);
  import jddf_pkg::*;

  // Configuration.
  logic [PosW-1:0] digit_count_q;
  logic            left_align_q;
  logic            zero_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= DigitCountReset;
      left_align_q  <= 1'b0;
      zero_fill_q   <= 1'b0;
    end else if (cfg_write_i) begin
      if (cfg_index_i == RegDigitCount) begin
        digit_count_q <= cfg_data_i[PosW-1:0];
      end
      if (cfg_index_i == RegLeftAlign) begin
        left_align_q <= cfg_data_i[0];
      end
      if (cfg_index_i == RegZeroFill) begin
        zero_fill_q <= cfg_data_i[0];
      end
    end
  end

  // Converter: several shift-and-add-3 steps per cycle.
  logic [ValueW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic              neg_q;

  always_comb begin
    bcd_d = bcd_q;
    bin_d = bin_q;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int d = 0; d < NumDec; d++) begin
        if (bcd_d[d*DigitW +: DigitW] >= DigitW'(5)) begin
          bcd_d[d*DigitW +: DigitW] = bcd_d[d*DigitW +: DigitW] + DigitW'(3);
        end
      end
      bcd_d = {bcd_d[BcdW-2:0], bin_d[ValueW-1]};
      bin_d = {bin_d[ValueW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= value_i[ValueW-1];
      // A negative number shows fill only, so its magnitude is never needed.
      bin_q <= value_i[ValueW-1] ? '0 : value_i;
      bcd_q <= '0;
    end else if (cmd_i.step) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  // Digit view, field width and number length.
  logic [DigitW-1:0] dec_w [NumDec];
  logic [PosW-1:0]   width_w;
  logic [PosW-1:0]   len_w;

  always_comb begin
    for (int d = 0; d < NumDec; d++) begin
      dec_w[d] = bcd_q[d*DigitW +: DigitW];
    end
  end

  always_comb begin
    len_w = PosW'(1);
    for (int d = 0; d < NumDec; d++) begin
      if (dec_w[d] != '0) begin
        len_w = PosW'(d + 1);
      end
    end
  end

  always_comb begin
    priority if (digit_count_q == '0) begin
      width_w = PosW'(1);
    end else if (digit_count_q > PosW'(MaxDigits)) begin
      width_w = PosW'(MaxDigits);
    end else begin
      width_w = digit_count_q;
    end
  end

  // Position walk.
  logic [PosW-1:0]   pos_q;
  logic [PosW-1:0]   rev_w;
  logic [PosW-1:0]   idx_w;
  logic              show_w;
  logic [DigitW-1:0] sel_digit_w;

  always_comb begin
    rev_w = width_w - PosW'(1) - pos_q;
    if (left_align_q) begin
      show_w = (pos_q < len_w);
      idx_w  = len_w - PosW'(1) - pos_q;
    end else begin
      show_w = (rev_w < len_w);
      idx_w  = rev_w;
    end
    show_w      = show_w && !neg_q;
    sel_digit_w = show_w ? dec_w[idx_w] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= '0;
    end else if (cmd_i.emit) begin
      pos_q <= pos_q + PosW'(1);
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      position_o <= pos_q;
      digit_o    <= sel_digit_w;
      blank_o    <= !show_w && !zero_fill_q;
      last_o     <= status_o.last_pos;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.last_pos = (pos_q == width_w - PosW'(1));

endmodule

@@ design/justified_decimal_digit_formatter_core.sv @@
// ----------------------------------------------------------------------------
// justified_decimal_digit_formatter_core
// Turns a signed 32-bit number into one digit-or-blank result per display
// position, leftmost first, with configurable width, justification and fill.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the input channel (in_valid_i high, in_stall_o low) carries
//   one value. The block then produces N results on the output channel, one
//   per display position from 0 to N-1, where N is the configured field width
//   (digit_count, 0 reads as 1 and values above ten read as ten). The final
//   result of a request has last_o set.
//   The binary to BCD converter works four bits a cycle, and the first result
//   is loaded into the output register once the conversion has finished and
//   the register is free. A new request is taken only after the previous one
//   is through; in_stall_o stays high until the last result has been loaded
//   into the output register.
//   A stall on the output holds the current result and freezes the position
//   walk; the converter is finished by then, so nothing else waits on it.
//   Configuration writes (cfg_valid_i with cfg_ready_o, always ready) set
//   digit_count, left_align and zero_fill; write them only while idle.
//   Reset clears the sequencer and the output valid flag and restores a width
//   of ten, right justification and blank fill.
// ----------------------------------------------------------------------------
module justified_decimal_digit_formatter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [jddf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [jddf_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [jddf_pkg::ValueW-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [jddf_pkg::PosW-1:0]          position_o,
  output logic [jddf_pkg::DigitW-1:0]        digit_o,
  output logic                               blank_o,
  output logic                               last_o
);
  import jddf_pkg::*;

  jddf_cmd_t    cmd;
  jddf_status_t status;

  assign cfg_ready_o = 1'b1;

  jddf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jddf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_o),
    .digit_o     (digit_o),
    .blank_o     (blank_o),
    .last_o      (last_o)
  );

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result loaded over a held result");

  // The converter is only restarted by an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_valid_i && !in_stall_o))
    else $error("load without an accepted request");

  // Loading the final position returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.last_pos) |=> (!in_stall_o && out_valid_o && last_o))
    else $error("block not idle after the final result");

endmodule
